>>> hdl/fractional_delay_line_core_assert.svh
// Assertion macros for the checker of the fractional delay line.
`ifndef FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH
`define FRACTIONAL_DELAY_LINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FDL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define FDL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/fdl_pkg.sv
// Types and constants of the fractional delay line.
`timescale 1ns / 1ps

package fdl_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int FRAC_BITS      = 16;
   localparam int DELAY_BITS     = 17;
   localparam int DEPTH          = 131072;
   localparam int ADDR_BITS      = $clog2(DEPTH);
   localparam int DIFF_BITS      = SAMPLE_BITS + 1;
   localparam int PROD_BITS      = DIFF_BITS + FRAC_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [FRAC_BITS-1:0]          frac_type;
   typedef logic [DELAY_BITS-1:0]         delay_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DELAY_WHOLE    = 2'd0,
      REG_DELAY_FRACTION = 2'd1
   } csr_index_type;

   // Per-sample control that travels from the address stage to the datapath.
   typedef struct packed {
      logic bypass;
      logic tap1_ok;
      logic tap2_ok;
   } tap_tag_type;

endpackage

>>> hdl/fdl_store.sv
// Sample store: one write port, two registered read ports, read-first.
`timescale 1ns / 1ps

module fdl_store
   import fdl_pkg::*;
(
   input  logic       clock,
   input  logic       wr_en,
   input  addr_type   wr_addr,
   input  sample_type wr_data,
   input  logic       rd_en,
   input  addr_type   rd_addr1,
   input  addr_type   rd_addr2,
   output sample_type rd_data1,
   output sample_type rd_data2
);

   sample_type mem [DEPTH];
   sample_type rd_data1_ff;
   sample_type rd_data2_ff;

   // Reads see the old entry when the same address is written in this cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data1_ff <= mem[rd_addr1];
         rd_data2_ff <= mem[rd_addr2];
      end
   end

   assign rd_data1 = rd_data1_ff;
   assign rd_data2 = rd_data2_ff;

endmodule

>>> hdl/fdl_addr.sv
// Write pointer, wrap flag and tap address generation.
`timescale 1ns / 1ps

module fdl_addr
   import fdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  delay_type   delay_whole,
   output addr_type    wr_addr,
   output addr_type    tap1_addr,
   output addr_type    tap2_addr,
   output tap_tag_type tag
);

   addr_type wp_ff;
   addr_type wp_in;
   logic     full_ff;
   logic     full_in;
   addr_type tap1;
   addr_type tap2;

   always_comb begin
      wp_in   = wp_ff;
      full_in = full_ff;
      if (advance) begin
         wp_in = wp_ff + addr_type'(1);
         if (&wp_ff) begin
            full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         full_ff <= full_in;
      end
   end

   always_comb begin
      tap1 = wp_ff - delay_whole[ADDR_BITS-1:0];
      tap2 = tap1 - addr_type'(1);
      // Entries below the pointer are written; after the first wrap all are.
      tag.bypass  = (delay_whole == '0);
      tag.tap1_ok = full_ff || (tap1 < wp_ff);
      tag.tap2_ok = full_ff || (tap2 < wp_ff);
   end

   assign wr_addr   = wp_ff;
   assign tap1_addr = tap1;
   assign tap2_addr = tap2;

endmodule

>>> hdl/fdl_interp.sv
// Interpolation pipeline: difference and product, then sum into the output register.
`timescale 1ns / 1ps

module fdl_interp
   import fdl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  tap_tag_type tag,
   input  sample_type  sample_in,
   input  sample_type  tap1_data,
   input  sample_type  tap2_data,
   input  frac_type    delay_fraction,
   output logic        take,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output sample_type  rsp_sample_out
);

   // stage 1: taps come out of the store
   logic        s1_valid_ff, s1_valid_in;
   tap_tag_type s1_tag_ff;
   sample_type  s1_sample_ff;
   // stage 2: product
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_bypass_ff;
   sample_type  s2_sample_ff;
   sample_type  s2_y1_ff;
   logic signed [PROD_BITS-1:0] s2_prod_ff, s2_prod_in;
   // output register
   logic        out_valid_ff, out_valid_in;
   sample_type  out_sample_ff, out_sample_in;

   logic out_ready;
   logic s2_take;
   logic s1_take;
   sample_type y1;
   sample_type y2;
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [PROD_BITS-1:0] shifted;

   always_comb begin
      out_ready = !out_valid_ff || !rsp_stall;
      s2_take   = !s2_valid_ff || out_ready;
      s1_take   = !s1_valid_ff || s2_take;

      s1_valid_in  = s1_take ? load : s1_valid_ff;
      s2_valid_in  = s2_take ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_ready ? s2_valid_ff : out_valid_ff;

      // Unwritten entries read as zero.
      y1   = s1_tag_ff.tap1_ok ? tap1_data : '0;
      y2   = s1_tag_ff.tap2_ok ? tap2_data : '0;
      diff = $signed({y2[SAMPLE_BITS-1], y2}) - $signed({y1[SAMPLE_BITS-1], y1});
      s2_prod_in = $signed({1'b0, delay_fraction}) * diff;

      // Arithmetic shift floors; the true sum always fits the sample width.
      shifted       = s2_prod_ff >>> FRAC_BITS;
      out_sample_in = s2_bypass_ff ? s2_sample_ff
                                   : s2_y1_ff + shifted[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && s1_take) begin
         s1_tag_ff    <= tag;
         s1_sample_ff <= sample_in;
      end
      if (s2_take && s1_valid_ff) begin
         s2_bypass_ff <= s1_tag_ff.bypass;
         s2_sample_ff <= s1_sample_ff;
         s2_y1_ff     <= y1;
         s2_prod_ff   <= s2_prod_in;
      end
      if (out_ready && s2_valid_ff) begin
         out_sample_ff <= out_sample_in;
      end
   end

   assign take           = s1_take;
   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

endmodule

>>> hdl/fractional_delay_line_core.sv
// Top level of the linear-interpolated fractional delay line.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_sample_in
//   rsp      out        rsp_valid/rsp_stall  rsp_sample_out
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One sample per cycle while req_stall is low; a transfer on req passes through
// the store read, product and sum registers before it shows on rsp.
// Reset clears the write pointer and the wrap flag; an entry not yet written
// since reset reads as zero, so no clearing pass runs and req is free at once.
// req_stall rises only when all three stages hold a sample and rsp_stall is high.
`timescale 1ns / 1ps

module fractional_delay_line_core
   import fdl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sample_type                req_sample_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sample_type                rsp_sample_out,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   delay_type   delay_whole_ff, delay_whole_in;
   frac_type    delay_fraction_ff, delay_fraction_in;
   logic        take;
   logic        accept;
   addr_type    wr_addr;
   addr_type    tap1_addr;
   addr_type    tap2_addr;
   tap_tag_type tag;
   sample_type  tap1_data;
   sample_type  tap2_data;

   assign csr_ready = 1'b1;

   always_comb begin
      delay_whole_in    = delay_whole_ff;
      delay_fraction_in = delay_fraction_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DELAY_WHOLE:    delay_whole_in    = csr_data[DELAY_BITS-1:0];
            REG_DELAY_FRACTION: delay_fraction_in = csr_data[FRAC_BITS-1:0];
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_whole_ff    <= '0;
         delay_fraction_ff <= '0;
      end else begin
         delay_whole_ff    <= delay_whole_in;
         delay_fraction_ff <= delay_fraction_in;
      end
   end

   assign req_stall = !take;
   assign accept    = req_valid && take;

   fdl_addr u_addr (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .delay_whole (delay_whole_ff),
      .wr_addr     (wr_addr),
      .tap1_addr   (tap1_addr),
      .tap2_addr   (tap2_addr),
      .tag         (tag)
   );

   fdl_store u_store (
      .clock    (clock),
      .wr_en    (accept),
      .wr_addr  (wr_addr),
      .wr_data  (req_sample_in),
      .rd_en    (accept),
      .rd_addr1 (tap1_addr),
      .rd_addr2 (tap2_addr),
      .rd_data1 (tap1_data),
      .rd_data2 (tap2_data)
   );

   fdl_interp u_interp (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .tag            (tag),
      .sample_in      (req_sample_in),
      .tap1_data      (tap1_data),
      .tap2_data      (tap2_data),
      .delay_fraction (delay_fraction_ff),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

>>> hdl/fdl_checker.sv
// Port-level checker for the fractional delay line, bound to the top level.
`timescale 1ns / 1ps
`include "fractional_delay_line_core_assert.svh"

module fdl_checker
   import fdl_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input sample_type req_sample_in,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input sample_type rsp_sample_out,
   input logic       csr_valid,
   input logic       csr_ready
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [2:0] pending_ff, pending_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // samples taken in but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `FDL_ASSERT_NOW(a_no_extra_rsp, clock, reset, rsp_xfer, pending_ff != 3'd0,
      "result delivered with no sample pending")
   `FDL_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall,
      (pending_ff == 3'd3) && rsp_valid && rsp_stall,
      "input stalled while the pipeline has room")
   `FDL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_sample_out),
      "stalled result changed or dropped")
   `FDL_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall,
      req_valid && $stable(req_sample_in),
      "stalled input changed or dropped")

   // csr writes are never stalled
   `FDL_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready,
      "configuration write not taken")

endmodule

bind fractional_delay_line_core fdl_checker u_fdl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_sample_in  (req_sample_in),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);
